// ===== rtl/core/ccc_pkg.sv =====
// ccc_pkg: shared types, limits and the month length table for the calendar clock
// used by ccc_tick_if, ccc_advance and calendar_clock_counter
package ccc_pkg;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_t;

  typedef struct packed {
    logic [9:0]  msec;
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  weekday;
  } time_t;

  typedef struct packed {
    time_t      tm;
    logic [6:0] changed;
  } result_t;

  localparam logic [5:0]  SEC_LAST    = 6'd59;
  localparam logic [5:0]  MIN_LAST    = 6'd59;
  localparam logic [4:0]  HOUR_LAST   = 5'd23;
  localparam logic [3:0]  MONTH_LAST  = 4'd12;
  localparam logic [13:0] YEAR_LAST   = 14'd9999;
  localparam logic [2:0]  WDAY_LAST   = 3'd6;
  localparam logic [4:0]  DAY_FIRST   = 5'd1;
  localparam logic [3:0]  MONTH_FIRST = 4'd1;
  localparam logic [3:0]  MONTH_FEB   = 4'd2;
  localparam logic [4:0]  DAYS_LONG   = 5'd31;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // last day of the month; leap when year divisible by 4, bad month acts as 31 days
  function automatic logic [4:0] days_in(input logic [13:0] year, input logic [3:0] month);
    logic [4:0] n;
    n = DAYS_LONG;
    if (month >= MONTH_FIRST && month <= MONTH_LAST) begin
      n = MONTH_LEN[month - MONTH_FIRST];
      if (month == MONTH_FEB && year[1:0] == 2'b00) begin
        n = n + 5'd1;
      end
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/ccc_tick_if.sv =====
// ccc_tick_if: input channel of the calendar clock, tick or load command word
// depends on ccc_pkg for the opcode type
interface ccc_tick_if;
  logic            valid;
  logic            ready;
  ccc_pkg::op_t    opcode;
  logic [9:0]      set_msec;
  logic [5:0]      set_sec;
  logic [5:0]      set_min;
  logic [4:0]      set_hour;
  logic [4:0]      set_day;
  logic [3:0]      set_month;
  logic [13:0]     set_year;
  logic [2:0]      set_weekday;

  modport source (
    output valid, opcode, set_msec, set_sec, set_min, set_hour, set_day, set_month,
           set_year, set_weekday,
    input  ready
  );
  modport sink (
    input  valid, opcode, set_msec, set_sec, set_min, set_hour, set_day, set_month,
           set_year, set_weekday,
    output ready
  );
endinterface

// ===== rtl/core/ccc_time_if.sv =====
// ccc_time_if: output channel of the calendar clock, current time and change mask
// no dependencies
interface ccc_time_if;
  logic        valid;
  logic        ready;
  logic [9:0]  out_msec;
  logic [5:0]  out_sec;
  logic [5:0]  out_min;
  logic [4:0]  out_hour;
  logic [4:0]  out_day;
  logic [3:0]  out_month;
  logic [13:0] out_year;
  logic [2:0]  out_weekday;
  logic [6:0]  changed_units;

  modport source (
    output valid, out_msec, out_sec, out_min, out_hour, out_day, out_month, out_year,
           out_weekday, changed_units,
    input  ready
  );
  modport sink (
    input  valid, out_msec, out_sec, out_min, out_hour, out_day, out_month, out_year,
           out_weekday, changed_units,
    output ready
  );
endinterface

// ===== rtl/core/ccc_advance.sv =====
// ccc_advance: next calendar state for one command word, carry cascade or load
// depends on ccc_pkg
module ccc_advance #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  ccc_pkg::op_t  op,
  input  ccc_pkg::time_t cur,
  input  ccc_pkg::time_t load,
  output ccc_pkg::time_t nxt,
  output logic [6:0]    changed
);

  localparam logic [9:0] MSEC_LAST = 10'(TICKS_PER_SECOND - 1);

  logic       wrap_msec, wrap_sec, wrap_min, wrap_hour, wrap_day, wrap_month;
  logic [4:0] day_last;
  ccc_pkg::time_t tk;

  always_comb begin
    day_last   = ccc_pkg::days_in(cur.year, cur.month);
    wrap_msec  = cur.msec >= MSEC_LAST;
    wrap_sec   = wrap_msec && cur.sec >= ccc_pkg::SEC_LAST;
    wrap_min   = wrap_sec && cur.min >= ccc_pkg::MIN_LAST;
    wrap_hour  = wrap_min && cur.hour >= ccc_pkg::HOUR_LAST;
    wrap_day   = wrap_hour && cur.day >= day_last;
    wrap_month = wrap_day && cur.month >= ccc_pkg::MONTH_LAST;

    tk = cur;
    tk.msec = wrap_msec ? 10'd0 : cur.msec + 10'd1;
    if (wrap_msec) begin
      tk.sec = wrap_sec ? 6'd0 : cur.sec + 6'd1;
    end
    if (wrap_sec) begin
      tk.min = wrap_min ? 6'd0 : cur.min + 6'd1;
    end
    if (wrap_min) begin
      tk.hour = wrap_hour ? 5'd0 : cur.hour + 5'd1;
    end
    if (wrap_hour) begin
      // weekday follows the day rollover
      tk.weekday = (cur.weekday >= ccc_pkg::WDAY_LAST) ? 3'd0 : cur.weekday + 3'd1;
      tk.day     = wrap_day ? ccc_pkg::DAY_FIRST : cur.day + 5'd1;
    end
    if (wrap_day) begin
      tk.month = wrap_month ? ccc_pkg::MONTH_FIRST : cur.month + 4'd1;
    end
    if (wrap_month) begin
      tk.year = (cur.year >= ccc_pkg::YEAR_LAST) ? 14'd0 : cur.year + 14'd1;
    end

    if (op == ccc_pkg::OP_SET) begin
      nxt     = load;
      changed = 7'd0;
    end else begin
      nxt     = tk;
      changed = {wrap_month, wrap_day, wrap_hour, wrap_min, wrap_sec, wrap_msec, 1'b1};
    end
  end

endmodule

// ===== rtl/core/calendar_clock_counter.sv =====
// calendar_clock_counter: millisecond clock and calendar, one result word per command word
// result: an accepted command's result is registered in the result register, or in the skid entry while rsp stalls
// throughput: one command per cycle while the skid entry is empty; a two-entry output stage (result register plus skid)
//   keeps taking commands while one result waits on a stalled rsp
// reset (rst, synchronous): time returns to 00:00:00.000, day 1 month 1 year 0, weekday 0;
//   both output entries are emptied
module calendar_clock_counter #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic              clk,
  input  logic              rst,
  ccc_tick_if.sink          req,
  ccc_time_if.source        rsp
);

  // calendar state, updated on every accepted command
  ccc_pkg::time_t  cur;
  ccc_pkg::time_t  cur_next;
  ccc_pkg::time_t  load;
  logic [6:0]      changed;
  logic            acc;

  // output stage: result register and skid entry behind it
  ccc_pkg::result_t res;
  logic             res_valid;
  ccc_pkg::result_t skid;
  logic             skid_valid;

  // only a full skid entry blocks new commands
  assign req.ready = !skid_valid;
  assign acc       = req.valid && req.ready;

  // load word gathered from the command fields
  always_comb begin
    load.msec    = req.set_msec;
    load.sec     = req.set_sec;
    load.min     = req.set_min;
    load.hour    = req.set_hour;
    load.day     = req.set_day;
    load.month   = req.set_month;
    load.year    = req.set_year;
    load.weekday = req.set_weekday;
  end

  // carry cascade: msec -> sec -> min -> hour -> day/weekday -> month -> year
  ccc_advance #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_advance (
    .op      (req.opcode),
    .cur     (cur),
    .load    (load),
    .nxt     (cur_next),
    .changed (changed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.msec    <= 10'd0;
      cur.sec     <= 6'd0;
      cur.min     <= 6'd0;
      cur.hour    <= 5'd0;
      cur.day     <= ccc_pkg::DAY_FIRST;
      cur.month   <= ccc_pkg::MONTH_FIRST;
      cur.year    <= 14'd0;
      cur.weekday <= 3'd0;
    end else if (acc) begin
      cur <= cur_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || rsp.ready) begin
      // result register free or draining this cycle
      if (skid_valid) begin
        // skid word moves up; no command is taken while skid is full
        res        <= skid;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= acc;
        if (acc) begin
          res.tm      <= cur_next;
          res.changed <= changed;
        end
      end
    end else if (acc) begin
      // result register stalled, park the new word in the skid entry
      skid.tm      <= cur_next;
      skid.changed <= changed;
      skid_valid   <= 1'b1;
    end
  end

  assign rsp.valid         = res_valid;
  assign rsp.out_msec      = res.tm.msec;
  assign rsp.out_sec       = res.tm.sec;
  assign rsp.out_min       = res.tm.min;
  assign rsp.out_hour      = res.tm.hour;
  assign rsp.out_day       = res.tm.day;
  assign rsp.out_month     = res.tm.month;
  assign rsp.out_year      = res.tm.year;
  assign rsp.out_weekday   = res.tm.weekday;
  assign rsp.changed_units = res.changed;

`ifndef ASSERT_OFF
  // skid entry only fills behind a held result
  a_skid_behind_res: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry valid while result register empty");

  // a command arriving on a stalled output lands in the skid entry
  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (acc && res_valid && !rsp.ready) |=> skid_valid)
    else $error("command lost on stalled output");

  // carries only ripple upward: the change mask is a run of low ones
  a_mask_cascade: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res.changed & (res.changed + 7'd1)) == 7'd0))
    else $error("change mask skips a unit");

  // calendar state moves only on an accepted command
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !acc |=> $stable(cur))
    else $error("calendar state changed without a command");
`endif

endmodule
